// ===== hdl/hldr_pkg.sv =====
// Shared types and constants for the header/length deframer ring.
// Used by every module under hdl; depends on nothing.
package hldr_pkg;

  localparam int SLOTS_DEF       = 8;
  localparam int FRAME_BYTES_DEF = 128;

  localparam int BYTE_W = 8;
  localparam int REQ_W  = 2;
  localparam int IDX_W  = 7;

  localparam logic [BYTE_W-1:0] HDR_RESET = 8'd42;

  localparam logic [REQ_W-1:0] REQ_BYTE    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd2;

  // Per-word status carried from the parser to the output stage.
  typedef struct packed {
    logic             done;
    logic             dropped;
    logic             rvalid;
    logic [IDX_W-1:0] idx;
  } status_t;

endpackage

// ===== hdl/hldr_parser.sv =====
// Byte parser and ring pointers: header hunt, length check, slot bookkeeping.
// Issues the writes and reads for hldr_store; depends on hldr_pkg.
module hldr_parser #(
  parameter int SLOTS       = hldr_pkg::SLOTS_DEF,
  parameter int FRAME_BYTES = hldr_pkg::FRAME_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            acc,
  input  logic [hldr_pkg::REQ_W-1:0]      req,
  input  logic [hldr_pkg::BYTE_W-1:0]     rx,
  input  logic [hldr_pkg::IDX_W-1:0]      idx,
  input  logic                            cfg_we,
  input  logic [hldr_pkg::BYTE_W-1:0]     cfg_wdata,
  output logic                            fs_we,
  output logic [$clog2(SLOTS)+$clog2(FRAME_BYTES)-1:0] fs_waddr,
  output logic [hldr_pkg::BYTE_W-1:0]     fs_wdata,
  output logic [$clog2(SLOTS)+$clog2(FRAME_BYTES)-1:0] fs_raddr,
  output logic                            sl_we,
  output logic [$clog2(SLOTS)-1:0]        sl_waddr,
  output logic [hldr_pkg::BYTE_W-1:0]     sl_wdata,
  output logic [$clog2(SLOTS)-1:0]        sl_raddr,
  output hldr_pkg::status_t               st,
  output logic [$clog2(SLOTS+1)-1:0]      count_nxt
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int OFS_W  = $clog2(FRAME_BYTES);
  localparam int CNT_W  = $clog2(SLOTS+1);
  localparam logic [hldr_pkg::BYTE_W-1:0] FB_MAX = hldr_pkg::BYTE_W'(FRAME_BYTES);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_HDR1 = 3'd1;
  localparam logic [2:0] PH_HDR2 = 3'd2;
  localparam logic [2:0] PH_LEN  = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;
  localparam logic [2:0] PH_SKIP = 3'd5;

  logic [2:0]                    phase_r, phase_nxt;
  logic [hldr_pkg::BYTE_W-1:0]   hdr_r;
  logic [hldr_pkg::BYTE_W-1:0]   exp_r, exp_nxt;
  logic [hldr_pkg::BYTE_W-1:0]   rcv_r, rcv_nxt;
  logic [hldr_pkg::BYTE_W-1:0]   rcv_inc;
  logic [SLOT_W-1:0]             wslot_r, wslot_nxt;
  logic [SLOT_W-1:0]             rslot_r, rslot_nxt;
  logic [CNT_W-1:0]              count_r;
  logic                          is_hdr;

  assign is_hdr  = (rx == hdr_r);
  assign rcv_inc = hldr_pkg::BYTE_W'(rcv_r + 1'b1);

  always_comb begin
    phase_nxt = phase_r;
    exp_nxt   = exp_r;
    rcv_nxt   = rcv_r;
    wslot_nxt = wslot_r;
    rslot_nxt = rslot_r;
    count_nxt = count_r;
    fs_we     = 1'b0;
    sl_we     = 1'b0;
    st.done    = 1'b0;
    st.dropped = 1'b0;
    st.rvalid  = 1'b0;
    st.idx     = idx;
    case (req)
      hldr_pkg::REQ_BYTE: begin
        unique case (phase_r)
          PH_IDLE: if (is_hdr) phase_nxt = PH_HDR1;
          PH_HDR1: phase_nxt = is_hdr ? PH_HDR2 : PH_IDLE;
          PH_HDR2: phase_nxt = is_hdr ? PH_LEN : PH_IDLE;
          PH_LEN: begin
            if (!is_hdr) begin
              if (rx == '0 || rx > FB_MAX) begin
                st.dropped = 1'b1;
                phase_nxt  = PH_IDLE;
              end else begin
                exp_nxt   = rx;
                rcv_nxt   = '0;
                phase_nxt = (count_r == CNT_W'(SLOTS)) ? PH_SKIP : PH_DATA;
              end
            end
          end
          PH_DATA: begin
            fs_we   = 1'b1;
            rcv_nxt = rcv_inc;
            if (rcv_inc == exp_r) begin
              sl_we     = 1'b1;
              wslot_nxt = (wslot_r == SLOT_W'(SLOTS-1)) ? '0 : SLOT_W'(wslot_r + 1'b1);
              count_nxt = CNT_W'(count_r + 1'b1);
              exp_nxt   = '0;
              rcv_nxt   = '0;
              st.done   = 1'b1;
              phase_nxt = PH_IDLE;
            end
          end
          PH_SKIP: begin
            rcv_nxt = rcv_inc;
            if (rcv_inc == exp_r) begin
              exp_nxt    = '0;
              rcv_nxt    = '0;
              st.dropped = 1'b1;
              phase_nxt  = PH_IDLE;
            end
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end
      hldr_pkg::REQ_READ: st.rvalid = (count_r != '0);
      hldr_pkg::REQ_RELEASE: begin
        if (count_r != '0) begin
          rslot_nxt = (rslot_r == SLOT_W'(SLOTS-1)) ? '0 : SLOT_W'(rslot_r + 1'b1);
          count_nxt = CNT_W'(count_r - 1'b1);
        end
      end
      default: ;
    endcase
    fs_we = fs_we & acc;
    sl_we = sl_we & acc;
  end

  assign fs_waddr = {wslot_r, rcv_r[OFS_W-1:0]};
  assign fs_wdata = rx;
  assign fs_raddr = {rslot_r, OFS_W'(idx)};
  assign sl_waddr = wslot_r;
  assign sl_wdata = exp_r;
  assign sl_raddr = rslot_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      hdr_r   <= hldr_pkg::HDR_RESET;
      exp_r   <= '0;
      rcv_r   <= '0;
      wslot_r <= '0;
      rslot_r <= '0;
      count_r <= '0;
    end else begin
      if (cfg_we) hdr_r <= cfg_wdata;
      if (acc) begin
        phase_r <= phase_nxt;
        exp_r   <= exp_nxt;
        rcv_r   <= rcv_nxt;
        wslot_r <= wslot_nxt;
        rslot_r <= rslot_nxt;
        count_r <= count_nxt;
      end
    end
  end

endmodule

// ===== hdl/hldr_store.sv =====
// Frame byte memory and slot length memory, both with registered synchronous reads.
// Forwards a length written in the same cycle it is read; depends on hldr_pkg.
module hldr_store #(
  parameter int SLOTS       = hldr_pkg::SLOTS_DEF,
  parameter int FRAME_BYTES = hldr_pkg::FRAME_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            acc,
  input  logic                            fs_we,
  input  logic [$clog2(SLOTS)+$clog2(FRAME_BYTES)-1:0] fs_waddr,
  input  logic [hldr_pkg::BYTE_W-1:0]     fs_wdata,
  input  logic [$clog2(SLOTS)+$clog2(FRAME_BYTES)-1:0] fs_raddr,
  input  logic                            sl_we,
  input  logic [$clog2(SLOTS)-1:0]        sl_waddr,
  input  logic [hldr_pkg::BYTE_W-1:0]     sl_wdata,
  input  logic [$clog2(SLOTS)-1:0]        sl_raddr,
  output logic [hldr_pkg::BYTE_W-1:0]     fs_q,
  output logic [hldr_pkg::BYTE_W-1:0]     len_q
);

  localparam int FS_DEPTH = SLOTS * (2 ** $clog2(FRAME_BYTES));

  logic [hldr_pkg::BYTE_W-1:0] fs_mem [FS_DEPTH];
  logic [hldr_pkg::BYTE_W-1:0] sl_mem [SLOTS];
  logic [hldr_pkg::BYTE_W-1:0] fs_q_r;
  logic [hldr_pkg::BYTE_W-1:0] sl_q_r;
  logic [hldr_pkg::BYTE_W-1:0] fwd_len_r;
  logic                        fwd_r;

  always_ff @(posedge clk) begin
    if (fs_we) fs_mem[fs_waddr] <= fs_wdata;
    if (acc) fs_q_r <= fs_mem[fs_raddr];
  end

  always_ff @(posedge clk) begin
    if (sl_we) sl_mem[sl_waddr] <= sl_wdata;
    if (acc) begin
      sl_q_r    <= sl_mem[sl_raddr];
      fwd_r     <= sl_we && (sl_waddr == sl_raddr);
      fwd_len_r <= sl_wdata;
    end
  end

  assign fs_q  = fs_q_r;
  assign len_q = fwd_r ? fwd_len_r : sl_q_r;

endmodule

// ===== hdl/hldr_outq.sv =====
// Read-data stage and output register with stall handling.
// Forms read_data and read_length from hldr_store results; depends on hldr_pkg.
module hldr_outq #(
  parameter int SLOTS = hldr_pkg::SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            acc,
  input  hldr_pkg::status_t               st,
  input  logic [$clog2(SLOTS+1)-1:0]      count_nxt,
  input  logic [hldr_pkg::BYTE_W-1:0]     fs_q,
  input  logic [hldr_pkg::BYTE_W-1:0]     len_q,
  input  logic                            out_stall,
  output logic                            in_stall,
  output logic                            out_valid,
  output logic                            out_frame_done,
  output logic                            out_frame_dropped,
  output logic [$clog2(SLOTS+1)-1:0]      out_frames_waiting,
  output logic                            out_read_valid,
  output logic [hldr_pkg::BYTE_W-1:0]     out_read_data,
  output logic [hldr_pkg::BYTE_W-1:0]     out_read_length
);

  localparam int CNT_W = $clog2(SLOTS+1);

  logic                        p1_valid_r;
  hldr_pkg::status_t           p1_st_r;
  logic [CNT_W-1:0]            p1_cnt_r;
  logic                        p1_adv;
  logic                        out_free;
  logic [hldr_pkg::BYTE_W-1:0] rdata;
  logic [hldr_pkg::BYTE_W-1:0] rlen;

  logic                        out_valid_r;
  logic                        done_r, dropped_r, rvalid_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [hldr_pkg::BYTE_W-1:0] rdata_r, rlen_r;

  assign out_free = !out_valid_r || !out_stall;
  assign p1_adv   = p1_valid_r && out_free;
  assign in_stall = p1_valid_r && !out_free;

  // Bytes past the stored length read as padding zeros.
  assign rdata = (p1_st_r.rvalid && ({1'b0, p1_st_r.idx} < len_q)) ? fs_q : '0;
  assign rlen  = (p1_cnt_r != '0) ? len_q : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) p1_valid_r <= 1'b1;
      else if (p1_adv) p1_valid_r <= 1'b0;
      if (p1_adv) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      p1_st_r  <= st;
      p1_cnt_r <= count_nxt;
    end
    if (p1_adv) begin
      done_r    <= p1_st_r.done;
      dropped_r <= p1_st_r.dropped;
      rvalid_r  <= p1_st_r.rvalid;
      cnt_r     <= p1_cnt_r;
      rdata_r   <= rdata;
      rlen_r    <= rlen;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_frame_done     = done_r;
  assign out_frame_dropped  = dropped_r;
  assign out_frames_waiting = cnt_r;
  assign out_read_valid     = rvalid_r;
  assign out_read_data      = rdata_r;
  assign out_read_length    = rlen_r;

endmodule

// ===== hdl/header_length_deframer_ring_top.sv =====
// Serial-byte deframer with a sync header, storing frames in a ring of slots.
// Every input word is one request: a received byte, a read of a byte of the
// oldest stored frame, or a release of that frame. Each accepted word yields
// exactly one result word with done/dropped flags, the number of frames still
// waiting, read data and the oldest frame's length.
// A frame is three sync bytes (more are skipped), a length byte of 1 up to
// FRAME_BYTES, then that many payload bytes; bad lengths and frames that find
// the ring full are dropped and flagged.
// Throughput: one word per cycle while in_stall is low. The accepting edge loads
// the read stage along with the synchronous frame and length memory reads, and
// the output register takes the word from the read stage when it is free. Each byte
// is one read-modify-write of the parser state plus one memory write, which
// sets the one-word rate.
// When the receiver stalls, the output register holds its word and the read
// stage still takes one more word; in_stall rises only when both are full.
// Reset (synchronous, active low) clears the parser, slot pointers, frame count
// and both pipeline stages, and restores the sync byte to '*'. Frame memory
// is not cleared; it is always written before it can be read. cfg_we may be
// written at any idle time to change the sync byte.
module header_length_deframer_ring_top #(
  parameter int SLOTS       = hldr_pkg::SLOTS_DEF,
  parameter int FRAME_BYTES = hldr_pkg::FRAME_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [hldr_pkg::BYTE_W-1:0]     cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [hldr_pkg::REQ_W-1:0]      in_req_type,
  input  logic [hldr_pkg::BYTE_W-1:0]     in_rx_byte,
  input  logic [hldr_pkg::IDX_W-1:0]      in_read_index,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_frame_done,
  output logic                            out_frame_dropped,
  output logic [$clog2(SLOTS+1)-1:0]      out_frames_waiting,
  output logic                            out_read_valid,
  output logic [hldr_pkg::BYTE_W-1:0]     out_read_data,
  output logic [hldr_pkg::BYTE_W-1:0]     out_read_length
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int ADDR_W = $clog2(SLOTS) + $clog2(FRAME_BYTES);
  localparam int CNT_W  = $clog2(SLOTS+1);

  logic                        acc;
  logic                        fs_we, sl_we;
  logic [ADDR_W-1:0]           fs_waddr, fs_raddr;
  logic [hldr_pkg::BYTE_W-1:0] fs_wdata, sl_wdata;
  logic [SLOT_W-1:0]           sl_waddr, sl_raddr;
  logic [hldr_pkg::BYTE_W-1:0] fs_q, len_q;
  hldr_pkg::status_t           st;
  logic [CNT_W-1:0]            count_nxt;

  // Take a word whenever the read stage is free or moving on.
  assign acc = in_valid && !in_stall;

  hldr_parser #(.SLOTS(SLOTS), .FRAME_BYTES(FRAME_BYTES)) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .req       (in_req_type),
    .rx        (in_rx_byte),
    .idx       (in_read_index),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fs_we     (fs_we),
    .fs_waddr  (fs_waddr),
    .fs_wdata  (fs_wdata),
    .fs_raddr  (fs_raddr),
    .sl_we     (sl_we),
    .sl_waddr  (sl_waddr),
    .sl_wdata  (sl_wdata),
    .sl_raddr  (sl_raddr),
    .st        (st),
    .count_nxt (count_nxt)
  );

  // Issue memory reads only for accepted words so a stalled result keeps its data.
  hldr_store #(.SLOTS(SLOTS), .FRAME_BYTES(FRAME_BYTES)) u_store (
    .clk      (clk),
    .acc      (acc),
    .fs_we    (fs_we),
    .fs_waddr (fs_waddr),
    .fs_wdata (fs_wdata),
    .fs_raddr (fs_raddr),
    .sl_we    (sl_we),
    .sl_waddr (sl_waddr),
    .sl_wdata (sl_wdata),
    .sl_raddr (sl_raddr),
    .fs_q     (fs_q),
    .len_q    (len_q)
  );

  hldr_outq #(.SLOTS(SLOTS)) u_outq (
    .clk                (clk),
    .rst_n              (rst_n),
    .acc                (acc),
    .st                 (st),
    .count_nxt          (count_nxt),
    .fs_q               (fs_q),
    .len_q              (len_q),
    .out_stall          (out_stall),
    .in_stall           (in_stall),
    .out_valid          (out_valid),
    .out_frame_done     (out_frame_done),
    .out_frame_dropped  (out_frame_dropped),
    .out_frames_waiting (out_frames_waiting),
    .out_read_valid     (out_read_valid),
    .out_read_data      (out_read_data),
    .out_read_length    (out_read_length)
  );

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_frames_waiting <= CNT_W'(SLOTS)))
    else $error("frame count beyond ring size");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_frame_done && out_frame_dropped))
    else $error("frame both stored and dropped");

  a_read_needs_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_read_valid) |-> (out_frames_waiting != '0))
    else $error("read valid with empty ring");

  a_len_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_frames_waiting == '0) == (out_read_length == '0)))
    else $error("read length disagrees with frame count");
`endif

endmodule
